FILE: rtl/fad_pkg.sv
package fad_pkg;

    localparam int RateW  = 16;
    localparam int MagW   = 32;
    localparam int TimeW  = 32;
    localparam int HoldW  = 16;
    localparam int CfgIdxW = 8;
    localparam int CfgDataW = 32;

    localparam logic [CfgIdxW-1:0] CfgAgitThrSq  = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] CfgStillThrSq = CfgIdxW'(1);
    localparam logic [CfgIdxW-1:0] CfgAgitHoldMs = CfgIdxW'(2);
    localparam logic [CfgIdxW-1:0] CfgStabHoldMs = CfgIdxW'(3);

    // (200 * 131)^2 and (50 * 131)^2 in raw sensor counts
    localparam logic [MagW-1:0]  RstAgitThrSq  = MagW'(686440000);
    localparam logic [MagW-1:0]  RstStillThrSq = MagW'(42902500);
    localparam logic [HoldW-1:0] RstAgitHoldMs = HoldW'(3000);
    localparam logic [HoldW-1:0] RstStabHoldMs = HoldW'(2000);

    typedef struct packed {
        logic [MagW-1:0]  agit_thr_sq;
        logic [MagW-1:0]  still_thr_sq;
        logic [HoldW-1:0] agit_hold_ms;
        logic [HoldW-1:0] stab_hold_ms;
    } t_cfg;

    typedef struct packed {
        logic             valid;
        logic [MagW-1:0]  mag_sq;
        logic [TimeW-1:0] time_ms;
        logic             clear_flags;
    } t_mag_beat;

    typedef struct packed {
        logic fall_event;
        logic agitation_event;
        logic fall_flag;
        logic agitation_flag;
        logic alarm_on;
    } t_result;

endpackage

FILE: rtl/fad_mag.sv
module fad_mag (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic signed [fad_pkg::RateW-1:0] i_rate_x,
    input  logic signed [fad_pkg::RateW-1:0] i_rate_y,
    input  logic signed [fad_pkg::RateW-1:0] i_rate_z,
    input  logic [fad_pkg::TimeW-1:0]       i_time_ms,
    input  logic                            i_clear_flags,
    input  logic                            i_dn_ready,
    output logic                            o_ready,
    output fad_pkg::t_mag_beat              o_beat
);

    logic signed [fad_pkg::MagW-1:0] w_ext_x;
    logic signed [fad_pkg::MagW-1:0] w_ext_y;
    logic signed [fad_pkg::MagW-1:0] w_ext_z;
    logic [fad_pkg::MagW-1:0]        w_sq_x;
    logic [fad_pkg::MagW-1:0]        w_sq_y;
    logic [fad_pkg::MagW-1:0]        w_sq_z;
    logic                            r_valid;
    logic [fad_pkg::MagW-1:0]        r_mag_sq;
    logic [fad_pkg::TimeW-1:0]       r_time_ms;
    logic                            r_clear_flags;

    assign w_ext_x = fad_pkg::MagW'(i_rate_x);
    assign w_ext_y = fad_pkg::MagW'(i_rate_y);
    assign w_ext_z = fad_pkg::MagW'(i_rate_z);

    // each square is at most 2^30, so the sum of three fits 32 bits unsigned
    assign w_sq_x = fad_pkg::MagW'(w_ext_x * w_ext_x);
    assign w_sq_y = fad_pkg::MagW'(w_ext_y * w_ext_y);
    assign w_sq_z = fad_pkg::MagW'(w_ext_z * w_ext_z);

    assign o_ready = !r_valid || i_dn_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_mag_sq      <= w_sq_x + w_sq_y + w_sq_z;
            r_time_ms     <= i_time_ms;
            r_clear_flags <= i_clear_flags;
        end
    end

    assign o_beat.valid       = r_valid;
    assign o_beat.mag_sq      = r_mag_sq;
    assign o_beat.time_ms     = r_time_ms;
    assign o_beat.clear_flags = r_clear_flags;

endmodule

FILE: rtl/fad_detect.sv
module fad_detect (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fad_pkg::t_mag_beat  i_beat,
    input  fad_pkg::t_cfg       i_cfg,
    input  logic                i_stall,
    output logic                o_ready,
    output logic                o_valid,
    output fad_pkg::t_result    o_result
);

    logic                      r_agit_timing;
    logic [fad_pkg::TimeW-1:0] r_agit_start;
    logic                      r_fall_armed;
    logic                      r_still_timing;
    logic [fad_pkg::TimeW-1:0] r_still_start;
    logic                      r_fall_sticky;
    logic                      r_agit_sticky;
    logic                      r_valid;
    fad_pkg::t_result          r_result;

    logic                      n_agit_timing;
    logic [fad_pkg::TimeW-1:0] n_agit_start;
    logic                      n_fall_armed;
    logic                      n_still_timing;
    logic [fad_pkg::TimeW-1:0] n_still_start;
    logic                      n_fall_sticky;
    logic                      n_agit_sticky;
    fad_pkg::t_result          n_result;

    logic                      w_vigorous;
    logic                      w_still;
    logic [fad_pkg::TimeW-1:0] w_still_elapsed;
    logic [fad_pkg::TimeW-1:0] w_agit_elapsed;
    logic                      w_fall_ev;
    logic                      w_agit_ev;
    logic                      w_take;

    assign o_ready = !r_valid || !i_stall;
    assign w_take  = o_ready && i_beat.valid;

    assign w_vigorous      = i_beat.mag_sq > i_cfg.agit_thr_sq;
    assign w_still         = i_beat.mag_sq < i_cfg.still_thr_sq;
    // elapsed time wraps with the timestamp
    assign w_still_elapsed = i_beat.time_ms - r_still_start;
    assign w_agit_elapsed  = i_beat.time_ms - r_agit_start;

    always_comb begin
        n_fall_armed   = r_fall_armed;
        n_still_timing = r_still_timing;
        n_still_start  = r_still_start;
        w_fall_ev      = 1'b0;
        // fall detector gates on the sticky agitation flag from before this beat
        if (w_vigorous && !r_agit_sticky) begin
            n_fall_armed   = 1'b1;
            n_still_timing = 1'b0;
        end else if (r_fall_armed) begin
            if (w_still) begin
                if (!r_still_timing) begin
                    n_still_timing = 1'b1;
                    n_still_start  = i_beat.time_ms;
                end else if (w_still_elapsed >= fad_pkg::TimeW'(i_cfg.stab_hold_ms)) begin
                    n_fall_armed   = 1'b0;
                    n_still_timing = 1'b0;
                    w_fall_ev      = 1'b1;
                end
            end else begin
                n_still_timing = 1'b0;
            end
        end
    end

    always_comb begin
        n_agit_timing = r_agit_timing;
        n_agit_start  = r_agit_start;
        w_agit_ev     = 1'b0;
        if (w_vigorous) begin
            if (!r_agit_timing) begin
                n_agit_timing = 1'b1;
                n_agit_start  = i_beat.time_ms;
            end else if (w_agit_elapsed >= fad_pkg::TimeW'(i_cfg.agit_hold_ms)) begin
                n_agit_timing = 1'b0;
                w_agit_ev     = 1'b1;
            end
        end else begin
            n_agit_timing = 1'b0;
            n_agit_start  = '0;
        end
    end

    always_comb begin
        n_fall_sticky = r_fall_sticky || w_fall_ev;
        n_agit_sticky = r_agit_sticky || w_agit_ev;
        // clear wins over a report on the same beat
        if (i_beat.clear_flags) begin
            n_fall_sticky = 1'b0;
            n_agit_sticky = 1'b0;
        end
        n_result.fall_event      = w_fall_ev;
        n_result.agitation_event = w_agit_ev;
        n_result.fall_flag       = n_fall_sticky;
        n_result.agitation_flag  = n_agit_sticky;
        n_result.alarm_on        = n_fall_sticky || n_agit_sticky;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid        <= 1'b0;
            r_agit_timing  <= 1'b0;
            r_agit_start   <= '0;
            r_fall_armed   <= 1'b0;
            r_still_timing <= 1'b0;
            r_still_start  <= '0;
            r_fall_sticky  <= 1'b0;
            r_agit_sticky  <= 1'b0;
        end else begin
            if (o_ready) begin
                r_valid <= i_beat.valid;
            end
            if (w_take) begin
                r_agit_timing  <= n_agit_timing;
                r_agit_start   <= n_agit_start;
                r_fall_armed   <= n_fall_armed;
                r_still_timing <= n_still_timing;
                r_still_start  <= n_still_start;
                r_fall_sticky  <= n_fall_sticky;
                r_agit_sticky  <= n_agit_sticky;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

FILE: rtl/fall_and_agitation_detector.sv
// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+----------------------------------------
// sample    | in        | i_valid / o_stall    | i_rate_x/y/z, i_time_ms, i_clear_flags
// result    | out       | o_valid / i_stall    | o_fall_event, o_agitation_event, flags
// config    | in        | i_cfg_valid / ready  | i_cfg_index, i_cfg_data
//
// One sample per cycle sustained while the result is not stalled; each sample is held in
// turn by the input register, squared-magnitude register and detector/result register.
// Synchronous active-low reset clears valids, detector state and loads default config.
// Each stage advances when it is empty or the stage after it moves, so bubbles collapse;
// once all three stages are full, a stalled result holds them all and stalls the input.
module fall_and_agitation_detector (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic signed [fad_pkg::RateW-1:0] i_rate_x,
    input  logic signed [fad_pkg::RateW-1:0] i_rate_y,
    input  logic signed [fad_pkg::RateW-1:0] i_rate_z,
    input  logic [fad_pkg::TimeW-1:0]        i_time_ms,
    input  logic                             i_clear_flags,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_fall_event,
    output logic                             o_agitation_event,
    output logic                             o_fall_flag,
    output logic                             o_agitation_flag,
    output logic                             o_alarm_on,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [fad_pkg::CfgIdxW-1:0]      i_cfg_index,
    input  logic [fad_pkg::CfgDataW-1:0]     i_cfg_data
);

    logic                             r_in_valid;
    logic signed [fad_pkg::RateW-1:0] r_rate_x;
    logic signed [fad_pkg::RateW-1:0] r_rate_y;
    logic signed [fad_pkg::RateW-1:0] r_rate_z;
    logic [fad_pkg::TimeW-1:0]        r_time_ms;
    logic                             r_clear_flags;
    fad_pkg::t_cfg                    r_cfg;

    logic                             w_mag_ready;
    logic                             w_det_ready;
    logic                             w_in_en;
    fad_pkg::t_mag_beat               w_mag_beat;
    fad_pkg::t_result                 w_result;

    assign w_in_en     = !r_in_valid || w_mag_ready;
    assign o_stall     = !w_in_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_en) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_en && i_valid) begin
            r_rate_x      <= i_rate_x;
            r_rate_y      <= i_rate_y;
            r_rate_z      <= i_rate_z;
            r_time_ms     <= i_time_ms;
            r_clear_flags <= i_clear_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.agit_thr_sq  <= fad_pkg::RstAgitThrSq;
            r_cfg.still_thr_sq <= fad_pkg::RstStillThrSq;
            r_cfg.agit_hold_ms <= fad_pkg::RstAgitHoldMs;
            r_cfg.stab_hold_ms <= fad_pkg::RstStabHoldMs;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                fad_pkg::CfgAgitThrSq: begin
                    r_cfg.agit_thr_sq <= i_cfg_data[fad_pkg::MagW-1:0];
                end
                fad_pkg::CfgStillThrSq: begin
                    r_cfg.still_thr_sq <= i_cfg_data[fad_pkg::MagW-1:0];
                end
                fad_pkg::CfgAgitHoldMs: begin
                    r_cfg.agit_hold_ms <= i_cfg_data[fad_pkg::HoldW-1:0];
                end
                fad_pkg::CfgStabHoldMs: begin
                    r_cfg.stab_hold_ms <= i_cfg_data[fad_pkg::HoldW-1:0];
                end
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    fad_mag u_mag (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (r_in_valid),
        .i_rate_x      (r_rate_x),
        .i_rate_y      (r_rate_y),
        .i_rate_z      (r_rate_z),
        .i_time_ms     (r_time_ms),
        .i_clear_flags (r_clear_flags),
        .i_dn_ready    (w_det_ready),
        .o_ready       (w_mag_ready),
        .o_beat        (w_mag_beat)
    );

    fad_detect u_detect (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_beat   (w_mag_beat),
        .i_cfg    (r_cfg),
        .i_stall  (i_stall),
        .o_ready  (w_det_ready),
        .o_valid  (o_valid),
        .o_result (w_result)
    );

    assign o_fall_event      = w_result.fall_event;
    assign o_agitation_event = w_result.agitation_event;
    assign o_fall_flag       = w_result.fall_flag;
    assign o_agitation_flag  = w_result.agitation_flag;
    assign o_alarm_on        = w_result.alarm_on;

endmodule

FILE: rtl/fad_checker.sv
module fad_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_valid,
    input logic                             o_stall,
    input logic signed [fad_pkg::RateW-1:0] i_rate_x,
    input logic signed [fad_pkg::RateW-1:0] i_rate_y,
    input logic signed [fad_pkg::RateW-1:0] i_rate_z,
    input logic [fad_pkg::TimeW-1:0]        i_time_ms,
    input logic                             i_clear_flags,
    input logic                             o_valid,
    input logic                             i_stall,
    input logic                             o_fall_event,
    input logic                             o_agitation_event,
    input logic                             o_fall_flag,
    input logic                             o_agitation_flag,
    input logic                             o_alarm_on,
    input logic                             i_cfg_valid,
    input logic                             o_cfg_ready,
    input logic [fad_pkg::CfgIdxW-1:0]      i_cfg_index,
    input logic [fad_pkg::CfgDataW-1:0]     i_cfg_data
);

    // a held result beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_fall_event) && $stable(o_agitation_event)
            && $stable(o_fall_flag) && $stable(o_agitation_flag))
        else $error("result beat changed while stalled");

    a_alarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_alarm_on == (o_fall_flag || o_agitation_flag)))
        else $error("alarm_on disagrees with sticky flags");

    // with the output stage empty every stage can advance
    a_no_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while output stage empty");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind fall_and_agitation_detector fad_checker u_fad_checker (.*);
